@@ hdl/sscc_pkg.sv @@
// ============================================================================
// SSCC validator package
// Shared types and constants for the SSCC check digit validator.
// ============================================================================
`default_nettype none

package sscc_pkg;

    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned COUNT_W     = 5;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned PREFIX_W    = 32;
    localparam int unsigned VERDICT_W   = 15;
    localparam int unsigned OUT_TDATA_W = 16;

    localparam logic [COUNT_W-1:0] CODE_LEN         = 5'd20;
    localparam logic [COUNT_W-1:0] COUNT_SAT        = 5'd21;
    localparam logic [COUNT_W-1:0] ID_END_POS       = 5'd2;
    localparam logic [COUNT_W-1:0] FIRST_PREFIX_POS = 5'd3;
    localparam logic [COUNT_W-1:0] LAST_PREFIX_POS  = 5'd10;
    localparam logic [COUNT_W-1:0] FIRST_SUM_POS    = 5'd2;
    localparam logic [COUNT_W-1:0] LAST_SUM_POS     = 5'd18;

    localparam logic [CHAR_W-1:0]   CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0]   CHAR_NINE    = 8'h39;
    localparam logic [PREFIX_W-1:0] PREFIX_RESET = 32'h3426_0311;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              present;
        logic              last;
    } char_beat_t;

    // The first member sits in the top bits, so err_empty ends up in bit 0.
    typedef struct packed {
        logic               all_valid;
        logic [DIGIT_W-1:0] received_check_digit;
        logic [DIGIT_W-1:0] computed_check_digit;
        logic               err_check;
        logic               err_prefix;
        logic               err_identifier;
        logic               err_characters;
        logic               err_length;
        logic               err_empty;
    } verdict_t;

    typedef struct packed {
        logic advance;
        logic emit;
    } step_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/sscc_in_reg.sv @@
// ============================================================================
// SSCC input register
// Holds one incoming character beat until the core consumes it.
// ============================================================================
`default_nettype none

module sscc_in_reg
    import sscc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire char_beat_t in_beat,
    input  wire logic       advance,
    output logic            held_valid,
    output char_beat_t      held_beat
);

    logic       valid_reg;
    logic       valid_next;
    char_beat_t beat_reg;

    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_beat  = beat_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg <= in_beat;
        end
    end

endmodule

`default_nettype wire

@@ hdl/sscc_core.sv @@
// ============================================================================
// SSCC validation core
// Running per-code state, prefix register and the verdict logic.
// ============================================================================
`default_nettype none

module sscc_core
    import sscc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire logic [PREFIX_W-1:0] cfg_data,
    input  wire step_ctrl_t          ctrl,
    input  wire char_beat_t          beat,
    output verdict_t                 verdict
);

    logic [PREFIX_W-1:0] prefix_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [DIGIT_W-1:0]  sum_reg;
    logic [DIGIT_W-1:0]  sum_next;
    logic                nondigit_reg;
    logic                nondigit_next;
    logic                id_mis_reg;
    logic                id_mis_next;
    logic                pre_mis_reg;
    logic                pre_mis_next;
    logic [DIGIT_W-1:0]  last_digit_reg;
    logic [DIGIT_W-1:0]  last_digit_next;

    logic               char_num;
    logic [DIGIT_W-1:0] digit;
    logic [2:0]         nib_idx;
    logic [DIGIT_W-1:0] want;
    logic [COUNT_W-1:0] addend;
    logic [5:0]         raw_sum;
    logic               early;
    logic [DIGIT_W-1:0] computed;

    assign char_num = (beat.code >= CHAR_ZERO) && (beat.code <= CHAR_NINE);
    assign digit    = beat.code[DIGIT_W-1:0];
    assign nib_idx  = 3'(LAST_PREFIX_POS[3:0] - count_reg[3:0]);
    assign want     = prefix_reg[{nib_idx, 2'b00} +: DIGIT_W];
    // Even positions carry weight three.
    assign addend   = count_reg[0] ? {1'b0, digit}
                                   : ({1'b0, digit} + {digit, 1'b0});
    assign raw_sum  = {2'b00, sum_reg} + {1'b0, addend};

    always_comb
    begin
        count_next      = count_reg;
        sum_next        = sum_reg;
        nondigit_next   = nondigit_reg;
        id_mis_next     = id_mis_reg;
        pre_mis_next    = pre_mis_reg;
        last_digit_next = last_digit_reg;
        if (beat.present)
        begin
            if (count_reg < COUNT_SAT)
            begin
                count_next = count_reg + 5'd1;
            end
            if (!char_num)
            begin
                nondigit_next = 1'b1;
            end
            else
            begin
                last_digit_next = digit;
                if ((count_reg < ID_END_POS) && (digit != 4'd0))
                begin
                    id_mis_next = 1'b1;
                end
                if ((count_reg >= FIRST_PREFIX_POS) && (count_reg <= LAST_PREFIX_POS)
                    && (want != digit))
                begin
                    pre_mis_next = 1'b1;
                end
                if ((count_reg >= FIRST_SUM_POS) && (count_reg <= LAST_SUM_POS))
                begin
                    if (raw_sum >= 6'd30)
                    begin
                        sum_next = 4'(raw_sum - 6'd30);
                    end
                    else if (raw_sum >= 6'd20)
                    begin
                        sum_next = 4'(raw_sum - 6'd20);
                    end
                    else if (raw_sum >= 6'd10)
                    begin
                        sum_next = 4'(raw_sum - 6'd10);
                    end
                    else
                    begin
                        sum_next = raw_sum[DIGIT_W-1:0];
                    end
                end
            end
        end
    end

    assign computed = (sum_next == 4'd0) ? 4'd0 : (4'd10 - sum_next);

    always_comb
    begin
        verdict.err_empty            = (count_next == 5'd0);
        verdict.err_length           = (count_next != CODE_LEN);
        verdict.err_characters       = nondigit_next;
        early                        = verdict.err_empty || verdict.err_length
                                       || verdict.err_characters;
        verdict.err_identifier       = !early && id_mis_next;
        verdict.err_prefix           = !early && pre_mis_next;
        verdict.err_check            = !early && (last_digit_next != computed);
        verdict.computed_check_digit = computed;
        verdict.received_check_digit = last_digit_next;
        verdict.all_valid            = !(early || verdict.err_identifier
                                       || verdict.err_prefix || verdict.err_check);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= PREFIX_RESET;
        end
        else if (cfg_write)
        begin
            prefix_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            sum_reg        <= '0;
            nondigit_reg   <= 1'b0;
            id_mis_reg     <= 1'b0;
            pre_mis_reg    <= 1'b0;
            last_digit_reg <= '0;
        end
        else if (ctrl.emit)
        begin
            count_reg      <= '0;
            sum_reg        <= '0;
            nondigit_reg   <= 1'b0;
            id_mis_reg     <= 1'b0;
            pre_mis_reg    <= 1'b0;
            last_digit_reg <= '0;
        end
        else if (ctrl.advance)
        begin
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            nondigit_reg   <= nondigit_next;
            id_mis_reg     <= id_mis_next;
            pre_mis_reg    <= pre_mis_next;
            last_digit_reg <= last_digit_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/sscc_out_reg.sv @@
// ============================================================================
// SSCC result register
// Holds one verdict beat until the downstream side takes it.
// ============================================================================
`default_nettype none

module sscc_out_reg
    import sscc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     load,
    input  wire verdict_t verdict_in,
    output logic          out_valid,
    input  wire logic     out_ready,
    output logic          out_free,
    output verdict_t      verdict_out
);

    logic     valid_reg;
    logic     valid_next;
    verdict_t data_reg;

    assign out_free    = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign verdict_out = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= verdict_in;
        end
    end

endmodule

`default_nettype wire

@@ hdl/sscc_code_validator.sv @@
// ============================================================================
// SSCC code validator
// Checks a streamed 20-digit SSCC: length, digits, AI 00, prefix, check digit.
// ============================================================================
//
//  Channel   Direction  Width  Contents
//  s_axis    in         8+1+1  character byte, present flag (tuser), end (tlast)
//  m_axis    out        16     one verdict beat per code
//  cfg       in         32     company prefix, packed BCD
//
// One character beat is taken every cycle unless the input is stalled; each beat
// waits in the input register and is folded into the running state as it leaves.
// The verdict is loaded into the result register at the edge at which the last
// beat leaves the input register.
// A last beat waits in the input register while a verdict is held downstream,
// and the character input stalls behind it.
// Reset clears all per-code state and loads the default prefix.
//
`default_nettype none

module sscc_code_validator
    import sscc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [CHAR_W-1:0]      s_axis_tdata,  // char_code
    input  wire logic                   s_axis_tlast,  // is_last
    input  wire logic                   s_axis_tuser,  // char_present
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // err_empty, err_length, err_characters, err_identifier, err_prefix,
    // err_check, computed_check_digit[3:0], received_check_digit[3:0],
    // all_valid, one zero pad bit
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [PREFIX_W-1:0]    cfg_data
);

    char_beat_t in_beat;
    char_beat_t held_beat;
    logic       held_valid;
    logic       out_free;
    step_ctrl_t ctrl;
    verdict_t   verdict;
    verdict_t   verdict_out;

    assign in_beat.code    = s_axis_tdata;
    assign in_beat.present = s_axis_tuser;
    assign in_beat.last    = s_axis_tlast;

    assign ctrl.advance = held_valid && (!held_beat.last || out_free);
    assign ctrl.emit    = ctrl.advance && held_beat.last;

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = {{(OUT_TDATA_W - VERDICT_W){1'b0}}, verdict_out};

    sscc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_beat    (in_beat),
        .advance    (ctrl.advance),
        .held_valid (held_valid),
        .held_beat  (held_beat)
    );

    sscc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .beat      (held_beat),
        .verdict   (verdict)
    );

    sscc_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (ctrl.emit),
        .verdict_in  (verdict),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_free    (out_free),
        .verdict_out (verdict_out)
    );

endmodule

`default_nettype wire

@@ hdl/sscc_checker.sv @@
// ============================================================================
// SSCC validator checker
// Port-level assertions on the verdict stream, bound to the top level.
// ============================================================================
`default_nettype none

module sscc_checker
    import sscc_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // A stalled verdict beat must hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("verdict beat changed while stalled");

    // The pass flag is set exactly when no error flag is.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[14] == !(|m_axis_tdata[5:0])))
        else $error("all_valid disagrees with the error flags");

    // Content checks are suppressed behind an early error.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (|m_axis_tdata[2:0]) |-> (m_axis_tdata[5:3] == 3'b000))
        else $error("content error reported behind an early error");

    // An empty code is also a wrong length, and both digits stay decimal.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[0] || m_axis_tdata[1])
                          && (m_axis_tdata[9:6] <= 4'd9) && (m_axis_tdata[13:10] <= 4'd9))
        else $error("inconsistent length flags or non-decimal digit");

endmodule

bind sscc_code_validator sscc_checker u_sscc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ test/sscc_verdict_checker.sv @@
// ============================================================================
// SSCC verdict checker
// Watches the character, verdict and prefix channels of the SSCC validator,
// keeps its own running model of the code being received, and compares every
// verdict beat field by field with the oldest predicted verdict.
// ============================================================================

module sscc_verdict_checker
    import sscc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    input  wire logic                   s_axis_tready,
    input  wire logic [CHAR_W-1:0]      s_axis_tdata,  // char_code
    input  wire logic                   s_axis_tlast,  // is_last
    input  wire logic                   s_axis_tuser,  // char_present
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // err_empty, err_length, err_characters, err_identifier, err_prefix,
    // err_check, computed_check_digit[3:0], received_check_digit[3:0],
    // all_valid, one zero pad bit
    input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [PREFIX_W-1:0]    cfg_data,
    output int                          failures,
    output int                          pending
);

    localparam int REPORT_LIMIT = 10;

    logic [PREFIX_W-1:0] prefix_model;
    logic [COUNT_W-1:0]  n_chars;
    logic [8:0]          digit_sum;
    logic                bad_char;
    logic                bad_ai;
    logic                bad_prefix;
    logic [DIGIT_W-1:0]  latest_digit;
    verdict_t            verdicts_due[$];
    int                  n_fail = 0;
    int                  fail_count = 0;
    int                  due_count = 0;

    assign failures = fail_count;
    assign pending  = due_count;

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            n_fail++;
            if (n_fail <= REPORT_LIMIT)
                $display("%0t: verdict field %s mismatch: expected %0d, got %0d",
                         $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : model
        logic [COUNT_W-1:0] pos;
        logic [DIGIT_W-1:0] d;
        logic [DIGIT_W-1:0] want_digit;
        int                 shift;
        logic               early;
        verdict_t           v;
        verdict_t           got;

        if (!rst_n)
        begin
            prefix_model = PREFIX_RESET;
            n_chars      = '0;
            digit_sum    = '0;
            bad_char     = 1'b0;
            bad_ai       = 1'b0;
            bad_prefix   = 1'b0;
            latest_digit = '0;
            verdicts_due.delete();
            due_count <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = verdict_t'(m_axis_tdata[VERDICT_W-1:0]);
                if (verdicts_due.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= REPORT_LIMIT)
                        $display("%0t: verdict beat 0x%h arrived with none outstanding",
                                 $time, m_axis_tdata);
                end
                else
                begin
                    v = verdicts_due.pop_front();
                    check_field("err_empty", v.err_empty, got.err_empty);
                    check_field("err_length", v.err_length, got.err_length);
                    check_field("err_characters", v.err_characters, got.err_characters);
                    check_field("err_identifier", v.err_identifier, got.err_identifier);
                    check_field("err_prefix", v.err_prefix, got.err_prefix);
                    check_field("err_check", v.err_check, got.err_check);
                    check_field("computed_check_digit", v.computed_check_digit,
                                got.computed_check_digit);
                    check_field("received_check_digit", v.received_check_digit,
                                got.received_check_digit);
                    check_field("all_valid", v.all_valid, got.all_valid);
                    check_field("pad", 0, m_axis_tdata[OUT_TDATA_W-1]);
                end
            end

            if (cfg_valid && cfg_ready)
                prefix_model = cfg_data;

            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser)
                begin
                    pos = n_chars;
                    if (n_chars < COUNT_SAT)
                        n_chars = n_chars + 1'b1;
                    if (s_axis_tdata < CHAR_ZERO || s_axis_tdata > CHAR_NINE)
                        bad_char = 1'b1;
                    else
                    begin
                        d = DIGIT_W'(s_axis_tdata - CHAR_ZERO);
                        latest_digit = d;
                        if (pos < ID_END_POS && d != 0)
                            bad_ai = 1'b1;
                        if (pos >= FIRST_PREFIX_POS && pos <= LAST_PREFIX_POS)
                        begin
                            shift = DIGIT_W * int'(pos - FIRST_PREFIX_POS);
                            want_digit = prefix_model[PREFIX_W - 1 - shift -: DIGIT_W];
                            if (want_digit != d)
                                bad_prefix = 1'b1;
                        end
                        // Even positions sit an odd distance from the right end.
                        if (pos >= FIRST_SUM_POS && pos <= LAST_SUM_POS)
                            digit_sum = digit_sum + (pos[0] ? 9'(d) : 9'(d) * 9'd3);
                    end
                end

                if (s_axis_tlast)
                begin
                    v = '0;
                    v.err_empty      = (n_chars == 0);
                    v.err_length     = (n_chars != CODE_LEN);
                    v.err_characters = bad_char;
                    early            = v.err_empty | v.err_length | v.err_characters;
                    v.computed_check_digit = DIGIT_W'((10 - digit_sum % 10) % 10);
                    v.received_check_digit = latest_digit;
                    v.err_identifier = !early && bad_ai;
                    v.err_prefix     = !early && bad_prefix;
                    v.err_check      = !early && (latest_digit != v.computed_check_digit);
                    v.all_valid      = !(early || v.err_identifier || v.err_prefix
                                         || v.err_check);
                    verdicts_due = {verdicts_due, v};

                    n_chars      = '0;
                    digit_sum    = '0;
                    bad_char     = 1'b0;
                    bad_ai       = 1'b0;
                    bad_prefix   = 1'b0;
                    latest_digit = '0;
                end
            end

            due_count  <= verdicts_due.size();
            fail_count <= n_fail;
        end
    end

endmodule

@@ test/tb_sscc_code_validator.sv @@
// ============================================================================
// SSCC code validator testbench
// Streams directed and random codes, well-formed SSCCs with random content and
// broken ones, through the validator across several prefix settings and
// handshake idling patterns, including a long receiver hold-off; a checker
// beside the block predicts and compares every verdict.
// ============================================================================

module tb_sscc_code_validator;
    import sscc_pkg::*;

    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 10;
    localparam int PHASE_ITEMS   = 200;
    localparam int BURST_CODES   = 60;

    logic                   clk            = 1'b0;
    logic                   rst_n          = 1'b0;
    logic                   s_axis_tvalid  = 1'b0;
    logic                   s_axis_tready;
    logic [CHAR_W-1:0]      s_axis_tdata   = '0;  // char_code
    logic                   s_axis_tlast   = 1'b0;  // is_last
    logic                   s_axis_tuser   = 1'b0;  // char_present
    logic                   m_axis_tvalid;
    logic                   m_axis_tready  = 1'b0;
    // err_empty, err_length, err_characters, err_identifier, err_prefix,
    // err_check, computed_check_digit[3:0], received_check_digit[3:0],
    // all_valid, one zero pad bit
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid      = 1'b0;
    logic                   cfg_ready;
    logic [PREFIX_W-1:0]    cfg_data       = '0;

    int                  src_idle_pct   = 0;
    int                  sink_stall_pct = 0;
    int                  holds_asked    = 0;
    int                  items_sent     = 0;
    int                  fail_total;
    int                  verdicts_pending;
    logic [PREFIX_W-1:0] cur_prefix     = PREFIX_RESET;
    logic [CHAR_W-1:0]   code_chars[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sscc_code_validator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    sscc_verdict_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .failures      (fail_total),
        .pending       (verdicts_pending)
    );

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Verdict receiver: random stalls, plus a long hold-off whenever one is asked.
    initial
    begin : sink
        int hold_left;
        int holds_done;

        hold_left  = 0;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (holds_done != holds_asked)
            begin
                holds_done++;
                hold_left = LONG_HOLD;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic send_beat(input logic [CHAR_W-1:0] code, input logic present,
                             input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tuser  <= present;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Sends code_chars; an empty code, or one closed by an absent character,
    // ends with a beat that carries no character.
    task automatic send_code(input bit absent_end);
        int n;

        n = code_chars.size();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 5)
                send_beat(CHAR_W'($urandom_range(255)), 1'b0, 1'b0);
            send_beat(code_chars[i], 1'b1, (i == n - 1) && !absent_end);
            items_sent++;
        end
        if (absent_end || n == 0)
        begin
            send_beat(CHAR_W'($urandom_range(255)), 1'b0, 1'b1);
            items_sent++;
        end
    endtask

    task automatic build_sscc();
        int                 digits[CODE_LEN];
        int                 total;
        logic [DIGIT_W-1:0] nib;

        total = 0;
        code_chars.delete();
        for (int i = 0; i < CODE_LEN - 1; i++)
        begin
            if (i < ID_END_POS)
                digits[i] = 0;
            else if (i >= FIRST_PREFIX_POS && i <= LAST_PREFIX_POS)
            begin
                nib = cur_prefix[PREFIX_W - 1 - DIGIT_W * (i - FIRST_PREFIX_POS) -: DIGIT_W];
                digits[i] = (nib > 9) ? $urandom_range(9) : nib;
            end
            else
                digits[i] = $urandom_range(9);
            if (i >= FIRST_SUM_POS && i <= LAST_SUM_POS)
                total += (i % 2 == 0) ? 3 * digits[i] : digits[i];
        end
        digits[CODE_LEN - 1] = (10 - total % 10) % 10;
        for (int i = 0; i < CODE_LEN; i++)
            code_chars = {code_chars, CHAR_W'(CHAR_ZERO + digits[i])};
    endtask

    task automatic build_random_code();
        int kind;
        int n;
        int at;

        kind = $urandom_range(99);
        if (kind < 70)
        begin
            build_sscc();
            at = $urandom_range(CODE_LEN - 1);
            n  = $urandom_range(1, 4);
            if (kind >= 40 && kind < 52)
                code_chars[at] = CHAR_W'(CHAR_ZERO + $urandom_range(9));
            else if (kind >= 52 && kind < 60)
                code_chars[at] = CHAR_W'($urandom_range(255));
            else if (kind >= 60 && $urandom_range(1))
                repeat (n) void'(code_chars.pop_back());
            else if (kind >= 60)
                repeat (n) code_chars = {code_chars, CHAR_W'(CHAR_ZERO + $urandom_range(9))};
        end
        else if (kind < 85)
        begin
            code_chars.delete();
            n = $urandom_range(25);
            repeat (n)
            begin
                if ($urandom_range(99) < 70)
                    code_chars = {code_chars, CHAR_W'(CHAR_ZERO + $urandom_range(9))};
                else
                    code_chars = {code_chars, CHAR_W'($urandom_range(255))};
            end
        end
        else
        begin
            code_chars.delete();
            repeat (CODE_LEN)
                code_chars = {code_chars, CHAR_W'(CHAR_ZERO + $urandom_range(9))};
            if ($urandom_range(1))
            begin
                code_chars[0] = CHAR_ZERO;
                code_chars[1] = CHAR_ZERO;
            end
        end
    endtask

    task automatic run_codes(input int item_goal);
        int start;

        start = items_sent;
        while (items_sent - start < item_goal)
        begin
            build_random_code();
            send_code($urandom_range(99) < 15);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (verdicts_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_phase(input logic [PREFIX_W-1:0] prefix, input int idle_pct,
                             input int stall_pct);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= prefix;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_prefix     = prefix;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
    endtask

    function automatic logic [PREFIX_W-1:0] random_bcd();
        logic [PREFIX_W-1:0] v;

        v = '0;
        for (int i = 0; i < PREFIX_W / DIGIT_W; i++)
            v = {v[PREFIX_W-DIGIT_W-1:0], DIGIT_W'($urandom_range(9))};
        return v;
    endfunction

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        build_sscc();
        send_code(1'b0);
        send_beat(8'h55, 1'b0, 1'b0);
        code_chars.delete();
        send_code(1'b1);
        code_chars = '{8'h2F};
        send_code(1'b0);
        code_chars = '{8'h3A};
        send_code(1'b0);
        code_chars = '{8'hFF};
        send_code(1'b0);
        code_chars = '{8'h00};
        send_code(1'b0);

        run_codes(PHASE_ITEMS);

        set_phase(32'h0000_0000, 45, 0);
        run_codes(PHASE_ITEMS);

        set_phase(32'h9999_9999, 0, 45);
        run_codes(PHASE_ITEMS);

        set_phase(random_bcd(), 26, 26);
        run_codes(PHASE_ITEMS);

        // The receiver holds off while short codes keep coming, so the block
        // fills up and must stall its character input.
        set_phase(32'h0A0B_0C0D, 0, 0);
        holds_asked++;
        repeat (BURST_CODES)
        begin
            code_chars.delete();
            code_chars = {code_chars, CHAR_W'(CHAR_ZERO + $urandom_range(9))};
            send_code(1'b0);
        end
        run_codes(PHASE_ITEMS - BURST_CODES);

        set_phase($urandom_range(32'h9999_9999), 26, 26);
        run_codes(PHASE_ITEMS);

        set_phase(random_bcd(), 0, 0);
        run_codes(PHASE_ITEMS);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_total == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/sscc_pkg.sv
hdl/sscc_in_reg.sv
hdl/sscc_core.sv
hdl/sscc_out_reg.sv
hdl/sscc_code_validator.sv
hdl/sscc_checker.sv
test/sscc_verdict_checker.sv
test/tb_sscc_code_validator.sv
